FILE: src/fsd_pkg.sv
// Package for the firmware status token detector.
// Holds the transaction structs, operation and event codes, and the token text.
// It depends on nothing else.
`timescale 1ns / 1ps
`default_nettype none

package fsd_pkg;

	localparam int WIN_DEPTH = 8;
	localparam int TOK_MAX_LEN = 9;
	localparam int POS_W = 7;
	localparam logic [POS_W-1:0] POS_MAX = '1;

	typedef enum logic [1:0] {
		OP_BYTE      = 2'd0,
		OP_CLEAR_ALL = 2'd1,
		OP_CLEAR_BT  = 2'd2
	} op_t;

	typedef enum logic [2:0] {
		EV_NONE       = 3'd0,
		EV_ASSERT     = 3'd1,
		EV_DUMP_DONE  = 3'd2,
		EV_BSP_READY  = 3'd3,
		EV_WIFI_READY = 3'd4,
		EV_BT_READY   = 3'd5
	} event_t;

	typedef enum logic {
		REG_WATCHED_CHANNEL = 1'b0,
		REG_HEADER_BYTES    = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] channel;
		logic [7:0] data_byte;
		logic       last_byte;
	} cmd_t;

	typedef struct packed {
		logic [2:0] event_code;
		logic       message_done;
		logic       bsp_is_ready;
		logic       wifi_is_ready;
		logic       bt_is_ready;
		logic       has_failed;
	} evt_t;

	// Token text, last character in the low byte.
	localparam logic [8*TOK_MAX_LEN-1:0] TOK_ASSERT = 72'("BSPASSERT");
	localparam logic [8*TOK_MAX_LEN-1:0] TOK_DUMP   = 72'("DUMPDONE");
	localparam logic [8*TOK_MAX_LEN-1:0] TOK_TRUNK  = 72'("trunk_W");
	localparam logic [8*TOK_MAX_LEN-1:0] TOK_WIFI   = 72'("WIFIREADY");
	localparam logic [8*TOK_MAX_LEN-1:0] TOK_BT     = 72'("BTREADY");

	localparam logic [3:0] LEN_ASSERT = 4'd9;
	localparam logic [3:0] LEN_DUMP   = 4'd8;
	localparam logic [3:0] LEN_TRUNK  = 4'd7;
	localparam logic [3:0] LEN_WIFI   = 4'd9;
	localparam logic [3:0] LEN_BT     = 4'd7;

	// The window holds the previous body bytes, newest at index zero.
	function automatic logic tok_match(
		input logic [8*TOK_MAX_LEN-1:0] text,
		input logic [3:0]               len,
		input logic [7:0]               cur,
		input logic [WIN_DEPTH-1:0][7:0] win
	);
		logic hit;
		hit = (text[7:0] == cur);
		for (int k = 1; k < TOK_MAX_LEN; k++) begin
			if ((4'(k) < len) && (win[k-1] != text[8*k +: 8])) begin
				hit = 1'b0;
			end
		end
		return hit;
	endfunction

endpackage

`default_nettype wire

FILE: src/firmware_status_token_detector.sv
// Each accepted command transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle; the input register and the result register
// advance together whenever the result register is empty or being taken.
// Reset clears the message state, the status flags and both configuration registers.
// Top level of the firmware status token detector; uses fsd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module firmware_status_token_detector (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	input  wire fsd_pkg::cmd_t cmd,
	output logic               evt_valid,
	input  wire logic          evt_ready,
	output fsd_pkg::evt_t      evt,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [2:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import fsd_pkg::*;

	logic                       valid_s1;
	cmd_t                       cmd_s1;
	logic                       advance;
	logic                       proc;
	logic [7:0]                 watched_q;
	logic [5:0]                 header_q;
	logic [WIN_DEPTH-1:0][7:0]  window_q;
	logic [4:0]                 hits_q;
	logic [POS_W-1:0]           pos_q;
	logic [7:0]                 msg_chan_q;
	logic [2:0]                 ready_q;
	logic                       fail_q;
	evt_t                       evt_q;
	logic                       evt_valid_q;

	logic                       first;
	logic                       body;
	logic [WIN_DEPTH-1:0][7:0]  win_eff;
	logic [4:0]                 hits_eff;
	logic [4:0]                 hits_new;
	logic [7:0]                 chan_eff;
	logic [2:0]                 ev;
	logic [2:0]                 ready_d;
	logic                       fail_d;
	logic                       done;
	logic [POS_W-1:0]           pos_d;

	assign advance   = !evt_valid_q || evt_ready;
	assign cmd_ready = !valid_s1 || advance;
	assign proc      = valid_s1 && advance;
	assign pready    = 1'b1;
	assign evt_valid = evt_valid_q;
	assign evt       = evt_q;

	always_comb begin
		prdata = {24'b0, watched_q};
		if (reg_idx_t'(paddr[2]) == REG_HEADER_BYTES) begin
			prdata = {26'b0, header_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			watched_q <= '0;
			header_q  <= '0;
		end else if (psel && penable && pwrite) begin
			case (reg_idx_t'(paddr[2]))
				REG_WATCHED_CHANNEL: watched_q <= pwdata[7:0];
				REG_HEADER_BYTES:    header_q  <= pwdata[5:0];
				default:             watched_q <= watched_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd_ready) begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_ready && cmd_valid) begin
			cmd_s1 <= cmd;
		end
	end

	always_comb begin
		first    = (pos_q == '0);
		body     = (pos_q >= {1'b0, header_q});
		win_eff  = first ? '0 : window_q;
		hits_eff = first ? '0 : hits_q;
		chan_eff = first ? cmd_s1.channel : msg_chan_q;
		hits_new = hits_eff;
		if (body) begin
			hits_new[0] = hits_eff[0] | tok_match(TOK_ASSERT, LEN_ASSERT, cmd_s1.data_byte, win_eff);
			hits_new[1] = hits_eff[1] | tok_match(TOK_DUMP, LEN_DUMP, cmd_s1.data_byte, win_eff);
			hits_new[2] = hits_eff[2] | tok_match(TOK_TRUNK, LEN_TRUNK, cmd_s1.data_byte, win_eff);
			hits_new[3] = hits_eff[3] | tok_match(TOK_WIFI, LEN_WIFI, cmd_s1.data_byte, win_eff);
			hits_new[4] = hits_eff[4] | tok_match(TOK_BT, LEN_BT, cmd_s1.data_byte, win_eff);
		end
		pos_d = (pos_q == POS_MAX) ? POS_MAX : pos_q + 1'b1;
		if (cmd_s1.last_byte) begin
			pos_d = '0;
		end
		ev      = EV_NONE;
		ready_d = ready_q;
		fail_d  = fail_q;
		done    = 1'b0;
		case (op_t'(cmd_s1.op))
			OP_CLEAR_ALL: begin
				ready_d = '0;
				fail_d  = 1'b0;
			end
			OP_CLEAR_BT: begin
				ready_d[2] = 1'b0;
			end
			OP_BYTE: begin
				if (cmd_s1.last_byte) begin
					done = 1'b1;
					if (chan_eff == watched_q) begin
						if (hits_new[0]) begin
							ev = EV_ASSERT;
						end else if (hits_new[1]) begin
							ev = EV_DUMP_DONE;
						end else if (hits_new[2]) begin
							ev = EV_BSP_READY;
						end else if (hits_new[3]) begin
							ev = EV_WIFI_READY;
						end else if (hits_new[4]) begin
							ev = EV_BT_READY;
						end
						if (hits_new[1:0] != '0) begin
							fail_d = 1'b1;
						end else if (hits_new[2]) begin
							ready_d[0] = 1'b1;
						end else if (hits_new[3]) begin
							ready_d[1] = 1'b1;
						end else if (hits_new[4]) begin
							ready_d[2] = 1'b1;
						end
					end
				end
			end
			default: begin
				ev = EV_NONE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= '0;
			hits_q      <= '0;
			pos_q       <= '0;
			msg_chan_q  <= '0;
			ready_q     <= '0;
			fail_q      <= 1'b0;
			evt_valid_q <= 1'b0;
		end else if (advance) begin
			evt_valid_q <= valid_s1;
			if (valid_s1) begin
				ready_q <= ready_d;
				fail_q  <= fail_d;
				if (op_t'(cmd_s1.op) == OP_BYTE) begin
					hits_q     <= hits_new;
					pos_q      <= pos_d;
					msg_chan_q <= chan_eff;
					window_q   <= body ? {win_eff[WIN_DEPTH-2:0], cmd_s1.data_byte} : win_eff;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (proc) begin
			evt_q.event_code    <= ev;
			evt_q.message_done  <= done;
			evt_q.bsp_is_ready  <= ready_d[0];
			evt_q.wifi_is_ready <= ready_d[1];
			evt_q.bt_is_ready   <= ready_d[2];
			evt_q.has_failed    <= fail_d;
		end
	end

	a_clear_all: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (op_t'(cmd_s1.op) == OP_CLEAR_ALL) |=> (ready_q == '0) && !fail_q)
		else $error("clear-all transaction left a status flag set");

	a_pos_reset: assert property (@(posedge clk) disable iff (!arst_n)
		proc && (op_t'(cmd_s1.op) == OP_BYTE) && cmd_s1.last_byte |=> (pos_q == '0))
		else $error("byte position not restarted after a last byte");

	a_event_done: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid_q && (evt_q.event_code != EV_NONE) |-> evt_q.message_done)
		else $error("event reported on a transaction that ended no message");

	a_fail_flag: assert property (@(posedge clk) disable iff (!arst_n)
		evt_valid_q && ((evt_q.event_code == EV_ASSERT) || (evt_q.event_code == EV_DUMP_DONE))
		|-> evt_q.has_failed)
		else $error("failure event without failure flag");

endmodule

`default_nettype wire

FILE: dv/firmware_status_token_detector_tb.sv
// Self-checking testbench for firmware_status_token_detector.
// Drives byte and clear transactions with random idling, programs the channel and header
// registers, and checks every status transaction. Depends on fsd_pkg and the top module.
`timescale 1ns / 1ps

module firmware_status_token_detector_tb;

	import fsd_pkg::*;

	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam logic [6:0] POS_LIMIT = 7'h7F;
	localparam evt_t NO_STATUS = '0;

	typedef struct {
		cmd_t cmd;
		bit   pinned;
		evt_t result;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        evt_valid;
	logic        evt_ready;
	evt_t        evt;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	string status_tokens [5] = '{"BSPASSERT", "DUMPDONE", "trunk_W", "WIFIREADY", "BTREADY"};
	event_t token_event [5] = '{EV_ASSERT, EV_DUMP_DONE, EV_BSP_READY, EV_WIFI_READY,
		EV_BT_READY};

	dir_row_t directed_rows [19] = '{
		'{'{OP_BYTE, 8'h00, 8'h00, 1'b1}, 1'b1, '{EV_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{'{OP_BYTE, 8'h00, "B", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'hFF, "T", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "R", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "E", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "A", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "D", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'hFF, "Y", 1'b1}, 1'b1, '{EV_BT_READY, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0}},
		'{'{OP_CLEAR_BT, 8'hFF, 8'hFF, 1'b1}, 1'b1, NO_STATUS},
		'{'{OP_UNUSED, 8'hFF, 8'hFF, 1'b1}, 1'b1, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "t", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "r", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "u", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "n", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "k", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "_", 1'b0}, 1'b0, NO_STATUS},
		'{'{OP_BYTE, 8'h00, "W", 1'b1}, 1'b1, '{EV_BSP_READY, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{'{OP_CLEAR_ALL, 8'h00, 8'h00, 1'b0}, 1'b1, NO_STATUS},
		'{'{OP_BYTE, 8'hFF, 8'hFF, 1'b1}, 1'b1, '{EV_NONE, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0}}
	};

	logic [7:0] watch_chan = '0;
	logic [5:0] skip_len = '0;
	logic [7:0] body_win [8] = '{default: 8'h00};
	logic [4:0] token_hits = '0;
	logic [6:0] byte_pos = '0;
	logic [7:0] msg_chan = '0;
	logic [2:0] ready_bits = '0;
	logic       failed = 1'b0;

	evt_t status_due [$];
	int   errors = 0;
	int   items_sent = 0;
	bit   steady = 1'b0;

	firmware_status_token_detector u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.evt_valid (evt_valid),
		.evt_ready (evt_ready),
		.evt       (evt),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #10 clk = ~clk;

	function automatic evt_t predict_status(input cmd_t c);
		evt_t   r;
		event_t ev;
		logic   hit;
		int     t;
		int     k;
		int     len;
		r = NO_STATUS;
		ev = EV_NONE;
		case (c.op)
		OP_CLEAR_ALL: begin
			ready_bits = '0;
			failed = 1'b0;
		end
		OP_CLEAR_BT: begin
			ready_bits[2] = 1'b0;
		end
		OP_BYTE: begin
			if (byte_pos == 0) begin
				body_win = '{default: 8'h00};
				token_hits = '0;
				msg_chan = c.channel;
			end
			if (byte_pos >= 7'(skip_len)) begin
				for (t = 0; t < 5; t++) begin
					len = status_tokens[t].len();
					hit = (status_tokens[t][len-1] == c.data_byte);
					for (k = 1; k < len; k++) begin
						if (body_win[k-1] != status_tokens[t][len-1-k]) begin
							hit = 1'b0;
						end
					end
					if (hit) begin
						token_hits[t] = 1'b1;
					end
				end
				for (k = 7; k > 0; k--) begin
					body_win[k] = body_win[k-1];
				end
				body_win[0] = c.data_byte;
			end
			if (byte_pos != POS_LIMIT) begin
				byte_pos++;
			end
			if (c.last_byte) begin
				r.message_done = 1'b1;
				if (msg_chan == watch_chan) begin
					for (t = 4; t >= 0; t--) begin
						if (token_hits[t]) begin
							ev = token_event[t];
						end
					end
					case (ev)
					EV_ASSERT, EV_DUMP_DONE: begin
						failed = 1'b1;
					end
					EV_BSP_READY: begin
						ready_bits[0] = 1'b1;
					end
					EV_WIFI_READY: begin
						ready_bits[1] = 1'b1;
					end
					EV_BT_READY: begin
						ready_bits[2] = 1'b1;
					end
					default: begin
					end
					endcase
				end
				byte_pos = '0;
			end
		end
		default: begin
		end
		endcase
		r.event_code = ev;
		r.bsp_is_ready = ready_bits[0];
		r.wifi_is_ready = ready_bits[1];
		r.bt_is_ready = ready_bits[2];
		r.has_failed = failed;
		return r;
	endfunction

	function automatic void check_field(input string name, input logic [2:0] want,
		input logic [2:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			errors++;
		end
	endfunction

	function automatic logic [7:0] noise_byte();
		string letters = "BSPADUMONEtrunk_WIFREADY";
		if ($urandom_range(0, 1) == 0) begin
			return letters[$urandom_range(0, letters.len() - 1)];
		end
		return 8'($urandom);
	endfunction

	task automatic send_cmd(input cmd_t c, input bit pinned, input evt_t pinned_val);
		int   gap;
		evt_t want;
		gap = steady ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!cmd_ready);
		want = predict_status(c);
		status_due.push_back(pinned ? pinned_val : want);
		items_sent++;
	endtask

	task automatic settle_results();
		cmd_valid <= 1'b0;
		while (status_due.size() != 0) @(posedge clk);
	endtask

	task automatic write_reg(input reg_idx_t idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
		REG_WATCHED_CHANNEL: begin
			watch_chan = value[7:0];
		end
		default: begin
			skip_len = value[5:0];
		end
		endcase
		@(posedge clk);
	endtask

	task automatic send_message();
		logic [7:0] msg_bytes [$];
		logic [7:0] chan;
		logic [7:0] b;
		string      tok;
		int         n_hdr;
		int         n_tok;
		int         mode;
		int         bad;
		int         i;
		int         j;
		cmd_t       c;
		chan = ($urandom_range(0, 3) != 0) ? watch_chan : 8'($urandom);
		n_hdr = skip_len;
		if ($urandom_range(0, 7) == 0) begin
			n_hdr = $urandom_range(0, skip_len + 1);
		end
		for (i = 0; i < n_hdr; i++) begin
			msg_bytes.push_back(noise_byte());
		end
		if ($urandom_range(0, 24) == 0) begin
			repeat ($urandom_range(120, 150)) msg_bytes.push_back(noise_byte());
		end
		n_tok = $urandom_range(0, 2);
		for (j = 0; j < n_tok; j++) begin
			repeat ($urandom_range(0, 4)) msg_bytes.push_back(noise_byte());
			tok = status_tokens[$urandom_range(0, 4)];
			mode = $urandom_range(0, 5);
			bad = $urandom_range(0, tok.len() - 1);
			for (i = 0; i < tok.len(); i++) begin
				if (mode == 1 && i == bad) begin
					break;
				end
				b = tok[i];
				if (mode == 0 && i == bad) begin
					b ^= 8'h20;
				end
				msg_bytes.push_back(b);
			end
		end
		repeat ($urandom_range(0, 3)) msg_bytes.push_back(noise_byte());
		if (msg_bytes.size() == 0) begin
			msg_bytes.push_back(noise_byte());
		end
		for (i = 0; i < msg_bytes.size(); i++) begin
			if ($urandom_range(0, 19) == 0) begin
				case ($urandom_range(0, 2))
				0: begin
					c.op = OP_CLEAR_ALL;
				end
				1: begin
					c.op = OP_CLEAR_BT;
				end
				default: begin
					c.op = OP_UNUSED;
				end
				endcase
				c.channel = 8'($urandom);
				c.data_byte = 8'($urandom);
				c.last_byte = 1'($urandom);
				send_cmd(c, 1'b0, NO_STATUS);
			end
			c.op = OP_BYTE;
			c.channel = (i == 0) ? chan : 8'($urandom);
			c.data_byte = msg_bytes[i];
			c.last_byte = (i == msg_bytes.size() - 1);
			send_cmd(c, 1'b0, NO_STATUS);
		end
	endtask

	always @(posedge clk) begin
		evt_t want;
		if (arst_n && evt_valid && evt_ready) begin
			if (status_due.size() == 0) begin
				$error("status transaction with no expected result: %h", evt);
				errors++;
			end else begin
				want = status_due.pop_front();
				check_field("event_code", want.event_code, evt.event_code);
				check_field("message_done", 3'(want.message_done), 3'(evt.message_done));
				check_field("bsp_is_ready", 3'(want.bsp_is_ready), 3'(evt.bsp_is_ready));
				check_field("wifi_is_ready", 3'(want.wifi_is_ready), 3'(evt.wifi_is_ready));
				check_field("bt_is_ready", 3'(want.bt_is_ready), 3'(evt.bt_is_ready));
				check_field("has_failed", 3'(want.has_failed), 3'(evt.has_failed));
			end
		end
	end

	initial begin
		int stall;
		forever begin
			stall = steady ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				evt_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			evt_ready <= 1'b1;
			do @(posedge clk); while (!evt_valid);
		end
	end

	initial begin
		int         phase;
		int         goal;
		logic [7:0] new_chan;
		logic [5:0] new_hdr;
		arst_n <= 1'b0;
		cmd_valid <= 1'b0;
		cmd <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (directed_rows[r]) begin
			send_cmd(directed_rows[r].cmd, directed_rows[r].pinned, directed_rows[r].result);
		end
		for (phase = 0; phase < 8; phase++) begin
			settle_results();
			new_chan = (phase == 0 || phase == 6) ? 8'h00 :
				(phase == 1 || phase == 4) ? 8'hFF : 8'($urandom);
			new_hdr = (phase == 1 || phase == 6) ? 6'd63 :
				(phase == 0 || phase == 3) ? 6'd0 : 6'($urandom_range(1, 6));
			write_reg(REG_WATCHED_CHANNEL, {24'($urandom), new_chan});
			write_reg(REG_HEADER_BYTES, {26'($urandom), new_hdr});
			steady = (phase == 3);
			goal = items_sent + 125;
			if (phase == 5) begin
				send_message();
				settle_results();
			end
			while (items_sent < goal) begin
				send_message();
			end
		end
		settle_results();
		repeat (6) @(posedge clk);
		if (errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#(10_000_000);
		$display("FAIL");
		$finish;
	end

endmodule
